>>> rtl/core/ftwa_pkg.sv
// shared types and constants for the wrench transform and averaging block
// no dependencies
package ftwa_pkg;
  localparam int GW = 32;   // gauge count width
  localparam int VW = 48;   // output value width
  localparam int SW = 48;   // scale width
  localparam int RW = 54;   // rotation row width
  localparam int CW = 18;   // rotation coefficient width
  localparam int OW = 32;   // offset width
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 54;

  typedef enum logic [CFG_IW-1:0] {
    REG_SCALE = 3'd0, REG_ROW_X = 3'd1, REG_ROW_Y = 3'd2, REG_ROW_Z = 3'd3,
    REG_OFF_X = 3'd4, REG_OFF_Y = 3'd5, REG_OFF_Z = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_WRENCH = 2'd0, KIND_SLOW = 2'd1, KIND_FAST = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic signed [VW-1:0] force_x;
    logic signed [VW-1:0] force_y;
    logic signed [VW-1:0] force_z;
    logic signed [VW-1:0] torque_x;
    logic signed [VW-1:0] torque_y;
    logic signed [VW-1:0] torque_z;
    logic                last_of_sample;
  } result_t;

  typedef struct packed {
    logic signed [GW-1:0] gauge_fx;
    logic signed [GW-1:0] gauge_fy;
    logic signed [GW-1:0] gauge_fz;
    logic signed [GW-1:0] gauge_tx;
    logic signed [GW-1:0] gauge_ty;
    logic signed [GW-1:0] gauge_tz;
  } sample_t;

  localparam logic signed [VW-1:0] MAX_V = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] MIN_V = {1'b1, {(VW-1){1'b0}}};

  // saturate a 128 bit value to 48 bits signed
  function automatic logic signed [VW-1:0] sat48(input logic signed [127:0] v);
    logic signed [127:0] mx;
    logic signed [127:0] mn;
    mx = 128'(MAX_V);
    mn = {{80{1'b1}}, MIN_V};
    if (v > mx) return MAX_V;
    if (v < mn) return MIN_V;
    return v[VW-1:0];
  endfunction
endpackage

>>> rtl/core/ftwa_if.sv
// valid/ready channel interface with a typed payload
// no dependencies
interface ftwa_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ftwa_mac.sv
// one lane: signed 64x64 multiply split into 32x32 partial products over cycles
// depends on ftwa_pkg
module ftwa_mac (
  input  logic                 clk,
  input  logic                 start,
  input  logic signed [63:0]   a,
  input  logic signed [63:0]   b,
  output logic signed [127:0]  prod,
  output logic                 done
);
  import ftwa_pkg::*;
  logic [63:0] ua_r, ub_r;
  logic        neg_r;
  logic [2:0]  step_r;
  logic [127:0] acc_r;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh;

  // steps: 1..4 accumulate one 32x32 partial product each
  always_comb begin
    pa = step_r[0] ? ua_r[31:0] : ua_r[63:32];
    pb = step_r[1] ? ub_r[63:32] : ub_r[31:0];
    case (step_r)
      3'd1: begin pa = ua_r[31:0];  pb = ub_r[31:0];  end
      3'd2: begin pa = ua_r[63:32]; pb = ub_r[31:0];  end
      3'd3: begin pa = ua_r[31:0];  pb = ub_r[63:32]; end
      3'd4: begin pa = ua_r[63:32]; pb = ub_r[63:32]; end
      default: begin pa = '0; pb = '0; end
    endcase
    pp = 64'(pa) * 64'(pb);
    case (step_r)
      3'd1:    pp_sh = 128'(pp);
      3'd2,
      3'd3:    pp_sh = 128'(pp) << 32;
      3'd4:    pp_sh = 128'(pp) << 64;
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua_r   <= a[63] ? 64'(-a) : a;
      ub_r   <= b[63] ? 64'(-b) : b;
      neg_r  <= a[63] ^ b[63];
      acc_r  <= '0;
      step_r <= 3'd1;
    end else if (step_r != 3'd0) begin
      acc_r  <= acc_r + pp_sh;
      step_r <= (step_r == 3'd4) ? 3'd0 : step_r + 3'd1;
    end
  end

  assign done = (step_r == 3'd0);
  assign prod = neg_r ? -$signed(acc_r) : $signed(acc_r);
endmodule

>>> rtl/core/ftwa_avg.sv
// boxcar average: ring memory of wrenches, running sums, floor mean
// depends on ftwa_pkg, ftwa_mac
module ftwa_avg #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [ftwa_pkg::VW-1:0] w [6],
  output logic signed [ftwa_pkg::VW-1:0] mean [6],
  output logic                 busy
);
  import ftwa_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUMW = VW + AW + 1;
  // floor(n/DEPTH) = (n*RECIP) >> RSH for every magnitude n below 2^(SUMW-1)
  localparam int RSH = SUMW - 1 + $clog2(DEPTH);
  localparam logic [127:0] RECIP =
    ((128'd1 << RSH) + 128'(DEPTH) - 128'd1) / 128'(DEPTH);

  // one memory per wrench element; reset clearing pass writes zeros
  logic [VW-1:0] ring [6][DEPTH];
  logic signed [SUMW-1:0] sum_r [6];
  logic [AW-1:0] pos_r;
  logic [AW:0]   clr_r;
  logic          clearing_r;
  logic [3:0]    ph_r;
  logic [VW-1:0] old_r [6];
  logic signed [SUMW-1:0] q_r [6];
  logic [SUMW-1:0] mag_r [6];
  logic signed [127:0] prod [6];
  logic [5:0] mdone;
  logic       mstart;

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      for (int i = 0; i < 6; i++) ring[i][clr_r[AW-1:0]] <= '0;
    end else if (ph_r == 4'd1) begin
      for (int i = 0; i < 6; i++) ring[i][pos_r] <= w[i];
    end
    if (start) begin
      for (int i = 0; i < 6; i++) old_r[i] <= ring[i][pos_r];
    end
  end

  logic signed [SUMW-1:0] sum_nxt [6];
  always_comb begin
    for (int i = 0; i < 6; i++)
      sum_nxt[i] = sum_r[i] + SUMW'(w[i]) - SUMW'($signed(old_r[i]));
  end

  // reciprocal multiply of each magnitude, four partial products per lane
  assign mstart = (ph_r == 4'd2);
  for (genvar i = 0; i < 6; i++) begin : g_div
    ftwa_mac u_mul (.clk(clk), .start(mstart), .a(64'(mag_r[i])), .b(RECIP[63:0]),
                    .prod(prod[i]), .done(mdone[i]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
      pos_r      <= '0;
      ph_r       <= '0;
      for (int i = 0; i < 6; i++) sum_r[i] <= '0;
    end else begin
      if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (32'(clr_r) == DEPTH - 1) clearing_r <= 1'b0;
      end
      case (ph_r)
        4'd0: if (start) ph_r <= 4'd1;
        4'd1: begin
          for (int i = 0; i < 6; i++) begin
            sum_r[i] <= sum_nxt[i];
            mag_r[i] <= sum_nxt[i][SUMW-1] ? ~sum_nxt[i] : sum_nxt[i];
          end
          pos_r <= (32'(pos_r) == DEPTH - 1) ? '0 : pos_r + 1'b1;
          ph_r  <= 4'd2;
        end
        4'd2: ph_r <= 4'd3;
        4'd3: if (&mdone) begin
          for (int i = 0; i < 6; i++) q_r[i] <= SUMW'(prod[i] >> RSH);
          ph_r <= 4'd0;
        end
        default: ph_r <= 4'd0;
      endcase
    end
  end

  // negative: floor(s/d) = -(floor((-s-1)/d)) - 1 = ~q
  always_comb begin
    for (int i = 0; i < 6; i++)
      mean[i] = sum_r[i][SUMW-1] ? VW'(~q_r[i]) : VW'(q_r[i]);
  end
  assign busy = clearing_r || (ph_r != 4'd0);
endmodule

>>> rtl/core/ft_wrench_transform_average.sv
// top level: scale, rotate and offset-cross a wrench, then two boxcar means
// depends on ftwa_pkg, ftwa_if, ftwa_mac, ftwa_avg
// result beats of a sample follow one another: wrench, slow mean, fast mean
// a new sample is taken only once all three result beats of the last one are taken
// five product phases on six 64x64 lanes of 32x32 partial products, then a mean stage
// reset: synchronous, clears control, then a clearing pass over the slow and fast
// rings during which no sample is taken
module ft_wrench_transform_average #(
  parameter int SLOW_DEPTH = 100,
  parameter int FAST_DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  ftwa_if.sink   in_ch,
  ftwa_if.source out_ch,
  input  logic                          cfg_we,
  input  logic [ftwa_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [ftwa_pkg::CFG_DW-1:0]  cfg_data
);
  import ftwa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_MUL = 6'b000010, S_WAIT = 6'b000100,
    S_NEXT = 6'b001000, S_AVG = 6'b010000, S_OUT = 6'b100000
  } state_t;

  // configuration registers
  logic signed [SW-1:0] scale_r;
  logic [RW-1:0] row_r [3];
  logic signed [OW-1:0] off_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= '0;
      row_r[0] <= RW'(64'd65536);
      row_r[1] <= RW'(64'd65536) << 18;
      row_r[2] <= RW'(64'd65536) << 36;
      for (int i = 0; i < 3; i++) off_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE: scale_r  <= cfg_data[SW-1:0];
        REG_ROW_X: row_r[0] <= cfg_data;
        REG_ROW_Y: row_r[1] <= cfg_data;
        REG_ROW_Z: row_r[2] <= cfg_data;
        REG_OFF_X: off_r[0] <= cfg_data[OW-1:0];
        REG_OFF_Y: off_r[1] <= cfg_data[OW-1:0];
        REG_OFF_Z: off_r[2] <= cfg_data[OW-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [63:0] coef(input logic [RW-1:0] row, input int c);
    return 64'($signed(row[c*CW +: CW]));
  endfunction

  // six lanes, reused over phases:
  //  phase 0: scale each gauge
  //  phase 1..3: lanes 0..2 R[i][j]*f[j], lanes 3..5 R[i][j]*t[j] for column j
  //  phase 4: cross terms off[a]*w[b], off[b]*w[a] for three rows
  state_t st_r;
  logic [2:0] ph_r;
  logic signed [GW-1:0] g_r [6];
  logic signed [VW-1:0] s_r [6];
  logic signed [127:0]  acc_r [6];
  logic signed [VW-1:0] w_r [6];
  logic signed [63:0] la [6], lb [6];
  logic signed [127:0] lp [6];
  logic [5:0] ldone;
  logic lstart;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      la[k] = '0; lb[k] = '0;
    end
    case (ph_r)
      3'd0: for (int k = 0; k < 6; k++) begin
        la[k] = 64'(g_r[k]); lb[k] = 64'(scale_r);
      end
      3'd1, 3'd2, 3'd3: for (int k = 0; k < 3; k++) begin
        la[k]   = coef(row_r[k], 32'(ph_r) - 1);
        lb[k]   = 64'(s_r[32'(ph_r) - 1]);
        la[k+3] = coef(row_r[k], 32'(ph_r) - 1);
        lb[k+3] = 64'(s_r[32'(ph_r) + 2]);
      end
      3'd4: for (int k = 0; k < 3; k++) begin
        la[k]   = 64'(off_r[(k+1)%3]); lb[k]   = 64'(w_r[(k+2)%3]);
        la[k+3] = 64'(off_r[(k+2)%3]); lb[k+3] = 64'(w_r[(k+1)%3]);
      end
      default: ;
    endcase
  end

  for (genvar k = 0; k < 6; k++) begin : g_lane
    ftwa_mac u_mac (.clk(clk), .start(lstart), .a(la[k]), .b(lb[k]),
                    .prod(lp[k]), .done(ldone[k]));
  end

  // averaging units
  logic avg_start;
  logic signed [VW-1:0] slow_m [6], fast_m [6];
  logic slow_busy, fast_busy;
  ftwa_avg #(.DEPTH(SLOW_DEPTH)) u_slow (.clk(clk), .rst_n(rst_n), .start(avg_start),
    .w(w_r), .mean(slow_m), .busy(slow_busy));
  ftwa_avg #(.DEPTH(FAST_DEPTH)) u_fast (.clk(clk), .rst_n(rst_n), .start(avg_start),
    .w(w_r), .mean(fast_m), .busy(fast_busy));

  logic [1:0] kind_r;
  result_t res;
  logic signed [VW-1:0] sel [6];

  assign lstart    = (st_r == S_MUL);
  assign avg_start = (st_r == S_NEXT) && (ph_r == 3'd4);
  assign in_ch.ready = (st_r == S_IDLE) && !slow_busy && !fast_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ph_r <= '0;
      kind_r <= KIND_WRENCH;
    end else begin
      case (st_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          g_r[0] <= in_ch.data.gauge_fx; g_r[1] <= in_ch.data.gauge_fy;
          g_r[2] <= in_ch.data.gauge_fz; g_r[3] <= in_ch.data.gauge_tx;
          g_r[4] <= in_ch.data.gauge_ty; g_r[5] <= in_ch.data.gauge_tz;
          for (int k = 0; k < 6; k++) acc_r[k] <= '0;
          ph_r <= '0;
          st_r <= S_MUL;
        end
        S_MUL:  st_r <= S_WAIT;
        S_WAIT: if (&ldone) st_r <= S_NEXT;
        S_NEXT: begin
          // merge lane products for this phase
          case (ph_r)
            3'd0: for (int k = 0; k < 6; k++) s_r[k] <= sat48(lp[k] >>> 24);
            3'd1, 3'd2, 3'd3: for (int k = 0; k < 6; k++) acc_r[k] <= acc_r[k] + lp[k];
            default: ;
          endcase
          if (ph_r == 3'd3) begin
            for (int k = 0; k < 3; k++) w_r[k] <= sat48(acc_r[k] + lp[k] >>> 16);
          end
          if (ph_r == 3'd4) begin
            for (int k = 0; k < 3; k++)
              w_r[k+3] <= sat48(((acc_r[k+3] <<< 8) + lp[k] - lp[k+3]) >>> 24);
            kind_r <= KIND_WRENCH;
            st_r <= S_AVG;
          end else begin
            ph_r <= ph_r + 3'd1;
            st_r <= S_MUL;
          end
        end
        S_AVG: if (!slow_busy && !fast_busy) st_r <= S_OUT;
        S_OUT: if (out_ch.ready) begin
          if (kind_r == KIND_FAST) st_r <= S_IDLE;
          else kind_r <= kind_r + 2'd1;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      case (kind_r)
        KIND_SLOW: sel[k] = slow_m[k];
        KIND_FAST: sel[k] = fast_m[k];
        default:   sel[k] = w_r[k];
      endcase
    end
    res.result_kind = kind_r;
    res.force_x = sel[0]; res.force_y = sel[1]; res.force_z = sel[2];
    res.torque_x = sel[3]; res.torque_y = sel[4]; res.torque_z = sel[5];
    res.last_of_sample = (kind_r == KIND_FAST);
  end

  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.data  = res;
endmodule

>>> rtl/core/ftwa_checker.sv
// port-level checks for the wrench transform block, bound to the top level
// depends on ftwa_pkg
module ftwa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_kind,
  input logic out_last
);
  import ftwa_pkg::*;
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind == KIND_FAST))) else $error("last flag");
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during output");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind != KIND_FAST |=> out_valid)
    else $error("sample results split");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_kind == KIND_WRENCH) else $error("order");
endmodule

bind ft_wrench_transform_average ftwa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.data.result_kind), .out_last(out_ch.data.last_of_sample));

>>> dv/ft_wrench_transform_average_tb.sv
// self-checking bench for the wrench transform and boxcar average block
// depends on ftwa_pkg, ftwa_if and the ft_wrench_transform_average rtl
module ft_wrench_transform_average_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ftwa_pkg::*;

  localparam int SLOW_N = 100;
  localparam int FAST_N = 2;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;
  // index past the register map, must be ignored
  localparam logic [CFG_IW-1:0] REG_NONE = 3'd7;
  localparam logic signed [127:0] TOP48 = 128'sd140737488355327;
  localparam logic signed [127:0] BOT48 = -128'sd140737488355328;

  // wrench predictor plus the queue of results still owed by the block
  class wrench_scoreboard;
    logic signed [SW-1:0] scale;
    logic signed [CW-1:0] rot[3][3];
    logic signed [OW-1:0] offs[3];
    logic signed [VW-1:0] slow_ring[SLOW_N][6];
    logic signed [VW-1:0] fast_ring[FAST_N][6];
    logic signed [63:0] slow_sum[6];
    logic signed [63:0] fast_sum[6];
    int slow_pos, fast_pos;
    result_t owed[$];
    int errors;

    function new();
      scale = '0;
      offs = '{default: '0};
      slow_sum = '{default: '0};
      fast_sum = '{default: '0};
      slow_pos = 0;
      fast_pos = 0;
      errors = 0;
      foreach (slow_ring[i, j]) slow_ring[i][j] = '0;
      foreach (fast_ring[i, j]) fast_ring[i][j] = '0;
      foreach (rot[i, j]) rot[i][j] = (i == j) ? 18'sd65536 : 18'sd0;
    endfunction

    function logic signed [VW-1:0] clamp(logic signed [127:0] v);
      if (v > TOP48) return TOP48[VW-1:0];
      if (v < BOT48) return BOT48[VW-1:0];
      return v[VW-1:0];
    endfunction

    function logic signed [63:0] floor_div(logic signed [63:0] s, logic signed [63:0] n);
      logic signed [63:0] q;
      q = s / n;
      if ((s % n) != 0 && s < 0) q = q - 1;
      return q;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] v);
      case (idx)
        REG_SCALE: scale = v[SW-1:0];
        REG_ROW_X, REG_ROW_Y, REG_ROW_Z: begin
          for (int c = 0; c < 3; c++) rot[idx-1][c] = v[CW*c +: CW];
        end
        REG_OFF_X: offs[0] = v[OW-1:0];
        REG_OFF_Y: offs[1] = v[OW-1:0];
        REG_OFF_Z: offs[2] = v[OW-1:0];
        default: ;
      endcase
    endfunction

    function result_t pack_result(kind_t k, logic signed [VW-1:0] w[6]);
      result_t r;
      r.result_kind = k;
      r.force_x = w[0];
      r.force_y = w[1];
      r.force_z = w[2];
      r.torque_x = w[3];
      r.torque_y = w[4];
      r.torque_z = w[5];
      r.last_of_sample = (k == KIND_FAST);
      return r;
    endfunction

    // accepted input beat: compute the three results it owes
    function void note_sample(sample_t smp);
      logic signed [GW-1:0] g[6];
      logic signed [VW-1:0] s[6], w[6], avg[6];
      logic signed [127:0] acc, cr;
      int a, b;
      g = '{smp.gauge_fx, smp.gauge_fy, smp.gauge_fz,
            smp.gauge_tx, smp.gauge_ty, smp.gauge_tz};
      for (int i = 0; i < 6; i++) s[i] = clamp((128'(g[i]) * 128'(scale)) >>> 24);
      for (int i = 0; i < 3; i++) begin
        acc = '0;
        for (int j = 0; j < 3; j++) acc = acc + 128'(rot[i][j]) * 128'(s[j]);
        w[i] = clamp(acc >>> 16);
      end
      // torque: rotated torque in q.40 plus offset cross rotated force
      for (int i = 0; i < 3; i++) begin
        a = (i + 1) % 3;
        b = (i + 2) % 3;
        acc = '0;
        for (int j = 0; j < 3; j++) acc = acc + 128'(rot[i][j]) * 128'(s[3+j]);
        acc = acc <<< 8;
        cr = 128'(offs[a]) * 128'(w[b]) - 128'(offs[b]) * 128'(w[a]);
        w[3+i] = clamp((acc + cr) >>> 24);
      end
      owed.push_back(pack_result(KIND_WRENCH, w));
      for (int i = 0; i < 6; i++) begin
        slow_sum[i] = slow_sum[i] + w[i] - slow_ring[slow_pos][i];
        slow_ring[slow_pos][i] = w[i];
        avg[i] = floor_div(slow_sum[i], SLOW_N);
      end
      slow_pos = (slow_pos + 1 >= SLOW_N) ? 0 : slow_pos + 1;
      owed.push_back(pack_result(KIND_SLOW, avg));
      for (int i = 0; i < 6; i++) begin
        fast_sum[i] = fast_sum[i] + w[i] - fast_ring[fast_pos][i];
        fast_ring[fast_pos][i] = w[i];
        avg[i] = floor_div(fast_sum[i], FAST_N);
      end
      fast_pos = (fast_pos + 1 >= FAST_N) ? 0 : fast_pos + 1;
      owed.push_back(pack_result(KIND_FAST, avg));
    endfunction

    function void cmp(string name, logic [VW-1:0] e, logic [VW-1:0] a);
      if (a !== e) begin
        $error("%s: expected %0d, got %0d", name, $signed(e), $signed(a));
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (owed.size() == 0) begin
        $error("result beat with nothing expected, kind %0d", got.result_kind);
        errors++;
        return;
      end
      e = owed.pop_front();
      cmp("result_kind", 48'(e.result_kind), 48'(got.result_kind));
      cmp("force_x", e.force_x, got.force_x);
      cmp("force_y", e.force_y, got.force_y);
      cmp("force_z", e.force_z, got.force_z);
      cmp("torque_x", e.torque_x, got.torque_x);
      cmp("torque_y", e.torque_y, got.torque_y);
      cmp("torque_z", e.torque_z, got.torque_z);
      cmp("last_of_sample", 48'(e.last_of_sample), 48'(got.last_of_sample));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic calm;          // no idling on either side while set
  int cycles;

  ftwa_if #(.T(sample_t)) in_ch ();
  ftwa_if #(.T(result_t)) out_ch ();

  ft_wrench_transform_average #(.SLOW_DEPTH(SLOW_N), .FAST_DEPTH(FAST_N)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wrench_scoreboard sb = new();

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side stalls at random, with a chance of one in ten, unless calm
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 10);
  end

  // beats are logged at the edge that takes them
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_sample(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // watchdog, generous against reset clearing plus stalled results
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ft_wrench_transform_average_tb: done, errors");
      $finish;
    end
  end

  task automatic send_sample(sample_t s);
    while (!calm && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_gauges(logic signed [GW-1:0] f, logic signed [GW-1:0] t);
    sample_t s;
    s = '{f, f, f, t, t, t};
    send_sample(s);
  endtask

  task automatic send_random(int count);
    sample_t s;
    logic [GW-1:0] g[6];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 6; i++) begin
        case ($urandom_range(3))
          0: g[i] = $urandom_range(2000) - 1000;
          1: g[i] = $urandom_range(2000000) - 1000000;
          default: g[i] = $urandom;
        endcase
      end
      s = '{g[0], g[1], g[2], g[3], g[4], g[5]};
      send_sample(s);
    end
  endtask

  // settle the block before a register write: all owed results back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DW-1:0] row_of(logic [CW-1:0] cx, logic [CW-1:0] cy,
                                              logic [CW-1:0] cz);
    return {cz, cy, cx};
  endfunction

  task automatic random_config();
    logic [63:0] r;
    r = {$urandom, $urandom};
    // mostly scales near unity so sums stay in range, sometimes full width
    if ($urandom_range(2) == 0) write_reg(REG_SCALE, CFG_DW'($signed(r[SW-1:0])));
    else write_reg(REG_SCALE, CFG_DW'($signed(48'(r[43:0]) - 48'sd8796093022208)));
    write_reg(REG_ROW_X, CFG_DW'({$urandom, $urandom}));
    write_reg(REG_ROW_Y, CFG_DW'({$urandom, $urandom}));
    write_reg(REG_ROW_Z, CFG_DW'({$urandom, $urandom}));
    write_reg(REG_OFF_X, CFG_DW'($signed($urandom)));
    write_reg(REG_OFF_Y, CFG_DW'($signed($urandom)));
    write_reg(REG_OFF_Z, CFG_DW'($signed($urandom)));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // unconfigured scale: extremes still give a zero wrench into both windows
    send_gauges(32'sh7FFFFFFF, 32'sh80000000);
    send_gauges(32'sh80000000, 32'sh7FFFFFFF);

    // unity scale, identity rotation, modest offsets
    wait_drained();
    write_reg(REG_SCALE, CFG_DW'(64'sd1 <<< 40));
    write_reg(REG_OFF_X, CFG_DW'(32'sd16777216));
    write_reg(REG_OFF_Y, CFG_DW'(-32'sd33554432));
    write_reg(REG_OFF_Z, CFG_DW'(32'sd8388608));
    write_reg(REG_NONE, '1);
    send_gauges(0, 0);
    send_gauges(1, -1);
    send_gauges(-1, 1);
    send_gauges(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_gauges(32'sh80000000, 32'sh80000000);
    send_sample('{1000, -2000, 3000, -400, 500, -600});

    // largest scale and extreme coefficients, extreme offsets
    wait_drained();
    write_reg(REG_SCALE, CFG_DW'(TOP48[SW-1:0]));
    write_reg(REG_ROW_X, row_of(18'h1FFFF, 18'h20000, 18'h00001));
    write_reg(REG_ROW_Y, row_of(18'h20000, 18'h1FFFF, 18'h3FFFF));
    write_reg(REG_ROW_Z, row_of(18'h1FFFF, 18'h1FFFF, 18'h20000));
    write_reg(REG_OFF_X, CFG_DW'(32'sh7FFFFFFF));
    write_reg(REG_OFF_Y, CFG_DW'(32'sh80000000));
    write_reg(REG_OFF_Z, CFG_DW'(32'sh7FFFFFFF));
    send_gauges(32'sh7FFFFFFF, 32'sh80000000);
    send_gauges(32'sh80000000, 32'sh7FFFFFFF);
    send_gauges(1, 1);
    send_gauges(0, -1);

    // most negative scale, offsets of -1 and +1 and the most negative offset
    wait_drained();
    write_reg(REG_SCALE, CFG_DW'($signed(BOT48[SW-1:0])));
    write_reg(REG_OFF_X, CFG_DW'(-32'sd1));
    write_reg(REG_OFF_Y, CFG_DW'(32'sd1));
    write_reg(REG_OFF_Z, CFG_DW'(32'sh80000000));
    send_gauges(32'sh7FFFFFFF, 32'sh80000000);
    send_gauges(-1, 1);
    send_gauges(12345, -54321);

    // random phases, one of them with no idling at all
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      random_config();
      calm = (ph == 2);
      send_random(55);
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("ft_wrench_transform_average_tb: done, clean");
    end else begin
      $display("ft_wrench_transform_average_tb: done, errors");
    end
    $finish;
  end
endmodule
